// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/gcns_pkg.sv =====
// types and constants of the graph coloring node selector
package gcns_pkg;

	// node storage
	localparam int MAX_NODES = 16;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);

	// configuration port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEURISTIC  = 1'b1;

	// item kinds
	localparam logic [1:0] KIND_ADD_NEIGHBOR = 2'd0;
	localparam logic [1:0] KIND_ASSIGN_COLOR = 2'd1;
	localparam logic [1:0] KIND_PROBE        = 2'd2;

	// heuristics
	localparam logic [1:0] MODE_FEWEST_COLORS = 2'd1;
	localparam logic [1:0] MODE_MOST_NEIGHBORS = 2'd2;
	localparam logic [1:0] MODE_RESET          = MODE_FEWEST_COLORS;

	// colors
	localparam logic [1:0] COLOR_NONE   = 2'd0;
	localparam logic [1:0] COLOR_RED    = 2'd1;
	localparam logic [1:0] COLOR_GREEN  = 2'd2;
	localparam logic [1:0] COLOR_YELLOW = 2'd3;

	// input transaction
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] node;
		logic [3:0] other_node;
		logic [1:0] color_code;
	} item_t;

	// result transaction
	typedef struct packed {
		logic       color_ok;
		logic [3:0] next_node;
		logic       next_found;
		logic       all_done;
	} result_t;

endpackage

// ===== hdl/graph_coloring_node_selector.sv =====
// graph coloring node selector: neighbor matrix, node colors and selection scan
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high and
//   busy low. It first adds a neighbor bit, assigns a color, or only probes.
//   Result channel: done is high for exactly one cycle with the result on
//   result; the receiver cannot stall, so it must take it in that cycle.
//   Configuration: cfg_we writes node_count (index 0) or heuristic_mode
//   (index 1) at once; write only while busy is low and no result is pending.
// Sequence:
//   One transaction passes from accept to done through the check, scan and
//   finish states: check tests the probed row, then the shared row read and
//   score unit visits one node per cycle over all MAX_NODES entries, then the
//   result is registered. busy drops when done rises, so the next start may
//   be taken in the done cycle; no new transaction is taken while one is in
//   flight.
// Reset:
//   arst_n clears all neighbor bits and colors, sets node_count to 0 and
//   heuristic_mode to fewest remaining colors, and returns the block to idle.
module graph_coloring_node_selector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  gcns_pkg::item_t                     item,
	output logic                                busy,
	output logic                                done,
	output gcns_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [gcns_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gcns_pkg::CFG_W-1:0]          cfg_data
);
	import gcns_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       node_count_q;
	logic [1:0]             mode_q;
	logic [MAX_NODES-1:0]   nbr_q [MAX_NODES];
	logic [1:0]             colors_q [MAX_NODES];
	logic [IDX_W-1:0]       idx_q;
	logic                   done_q;

	logic [IDX_W-1:0]       node_q;
	logic [1:0]             color_q;
	logic                   ok_q;
	logic                   found_q;
	logic                   all_q;
	logic [CNT_W-1:0]       best_q;
	logic [IDX_W-1:0]       pick_q;
	result_t                result_q;

	logic [CNT_W-1:0]       n_sat;
	logic [MAX_NODES-1:0]   pmask;
	logic [IDX_W-1:0]       rd_addr;
	logic [MAX_NODES-1:0]   row;
	logic [MAX_NODES-1:0]   clash;
	logic [3:0]             used;
	logic [2:0]             free_colors;
	logic [CNT_W-1:0]       score;
	logic                   mode_active;
	logic                   cand;
	logic                   better;
	logic                   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// node count saturates at the storage depth
	assign n_sat = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;

	// present node mask
	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			pmask[j] = (CNT_W'(j) < n_sat);
		end
	end

	// shared row read: probed node in check, scan index in scan
	assign rd_addr = (state_q == ST_CHECK) ? node_q : idx_q;
	assign row     = nbr_q[rd_addr] & pmask;

	// per-neighbor color compare and used color set
	always_comb begin
		used = 4'b0000;
		for (int j = 0; j < MAX_NODES; j++) begin
			clash[j] = row[j] && (colors_q[j] == color_q);
			if (row[j]) begin
				used = used | (4'b0001 << colors_q[j]);
			end
		end
	end

	// score of the row under the selected heuristic
	assign free_colors = ~used[3:1];
	always_comb begin
		if (mode_q == MODE_FEWEST_COLORS) begin
			score = CNT_W'($countones(free_colors));
		end else begin
			score = CNT_W'($countones(row));
		end
	end

	assign mode_active = (mode_q == MODE_FEWEST_COLORS) || (mode_q == MODE_MOST_NEIGHBORS);
	assign cand = (CNT_W'(idx_q) < n_sat) && (colors_q[idx_q] == COLOR_NONE);

	// strict improvement keeps the first winner
	always_comb begin
		if (!found_q) begin
			better = 1'b1;
		end else if (mode_q == MODE_FEWEST_COLORS) begin
			better = (score < best_q);
		end else begin
			better = (score > best_q);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			mode_q       <= MODE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_COUNT: node_count_q <= cfg_data[CNT_W-1:0];
				REG_HEURISTIC:  mode_q       <= cfg_data[1:0];
				default:        ;
			endcase
		end
	end

	// graph state updated by accepted transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				nbr_q[i]    <= '0;
				colors_q[i] <= COLOR_NONE;
			end
		end else if (accept) begin
			case (item.kind)
				KIND_ADD_NEIGHBOR: nbr_q[item.node][item.other_node] <= 1'b1;
				KIND_ASSIGN_COLOR: colors_q[item.node] <= item.color_code;
				default:           ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(MAX_NODES - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					node_q  <= item.node;
					color_q <= item.color_code;
				end
			end
			ST_CHECK: begin
				ok_q    <= ~|clash;
				found_q <= 1'b0;
				all_q   <= 1'b1;
				best_q  <= '0;
				pick_q  <= '0;
			end
			ST_SCAN: begin
				if (cand) begin
					all_q <= 1'b0;
					if (mode_active && better) begin
						found_q <= 1'b1;
						best_q  <= score;
						pick_q  <= idx_q;
					end
				end
			end
			ST_FINISH: begin
				result_q.color_ok   <= ok_q;
				result_q.next_node  <= found_q ? 4'(pick_q) : 4'd0;
				result_q.next_found <= found_q;
				result_q.all_done   <= all_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/gcns_checker.sv =====
// port-level checker for the graph coloring node selector, with its bind
`include "assert_macros.svh"

module gcns_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input gcns_pkg::result_t             result
);
	import gcns_pkg::*;

	logic accept;
	assign accept = start && !busy;

	// accepted transaction makes the block busy
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy)
	// result strobe only while idle
	`ASSERT_IMPLIES(a_done_when_idle, clk, arst_n, done, !busy)
	// result strobe lasts one cycle
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	// nothing selected reports node zero
	`ASSERT_IMPLIES(a_no_pick_zero, clk, arst_n, done && !result.next_found, result.next_node == 4'd0)
	// each accepted transaction is followed by its result strobe
	`ASSERT_IMPLIES(a_latency, clk, arst_n, accept, ##(MAX_NODES + 3) done)

endmodule

bind graph_coloring_node_selector gcns_checker u_gcns_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== dv/graph_coloring_node_selector_tb.sv =====
// testbench for the graph coloring node selector: random driver, result monitor and predictor
`timescale 1ns / 100ps

module graph_coloring_node_selector_tb;
	import gcns_pkg::*;

	// heuristic codes that select nothing, and the spare item kind
	localparam logic [1:0] MODE_IDLE_LOW  = 2'd0;
	localparam logic [1:0] MODE_IDLE_HIGH = 2'd3;
	localparam logic [1:0] KIND_SPARE     = 2'd3;
	localparam int LATENCY_CYCLES = MAX_NODES + 3;
	localparam int PHASE_ITEMS    = 55;
	localparam int NUM_PHASES     = 13;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic busy;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// model of the block state and its registers
	logic [MAX_NODES-1:0] nbr_rows [MAX_NODES];
	logic [1:0] node_color [MAX_NODES];
	logic [4:0] node_count_cfg = 5'd0;
	logic [1:0] mode_cfg = MODE_RESET;

	item_t pending_items[$];
	result_t expected_results[$];
	int items_queued = 0;
	int results_seen = 0;
	int failures = 0;
	int gap_left = 0;
	int burst_left = 0;
	int settings_seen = 0;
	int kind_count [4] = '{0, 0, 0, 0};
	int found_count = 0;
	int all_colored_count = 0;

	// random settings for the random phases, extremes included
	int phase_counts [NUM_PHASES] = '{3, 2, 5, 8, 1, 16, 12, 31, 16, 17, 0, 16, 7};
	logic [1:0] phase_modes [NUM_PHASES] = '{MODE_FEWEST_COLORS, MODE_MOST_NEIGHBORS,
		MODE_FEWEST_COLORS, MODE_MOST_NEIGHBORS, MODE_IDLE_HIGH, MODE_MOST_NEIGHBORS,
		MODE_FEWEST_COLORS, MODE_IDLE_LOW, MODE_FEWEST_COLORS, MODE_MOST_NEIGHBORS,
		MODE_MOST_NEIGHBORS, MODE_FEWEST_COLORS, MODE_MOST_NEIGHBORS};

	graph_coloring_node_selector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		for (int k = 0; k < MAX_NODES; k++) begin
			nbr_rows[k] = '0;
			node_color[k] = COLOR_NONE;
		end
	end

	// apply one transaction to the model and work out its selection result
	function automatic result_t predict_selection(input item_t it);
		int n;
		int i;
		int j;
		int score;
		int best;
		logic [MAX_NODES:0] span;
		logic [MAX_NODES-1:0] pmask;
		logic [MAX_NODES-1:0] row;
		logic [3:0] used;
		logic ok;
		logic found;
		logic all_col;
		logic [3:0] pick;
		result_t res;

		n = (node_count_cfg > MAX_NODES) ? MAX_NODES : int'(node_count_cfg);
		span = ({{MAX_NODES{1'b0}}, 1'b1} << n) - 1'b1;
		pmask = span[MAX_NODES-1:0];
		kind_count[it.kind]++;

		case (it.kind)
			KIND_ADD_NEIGHBOR: nbr_rows[it.node][it.other_node] = 1'b1;
			KIND_ASSIGN_COLOR: node_color[it.node] = it.color_code;
			default: ;
		endcase

		// literal color compare against present neighbors
		ok = 1'b1;
		row = nbr_rows[it.node] & pmask;
		for (j = 0; j < n; j++)
			if (row[j] && node_color[j] == it.color_code)
				ok = 1'b0;

		// scan present uncolored nodes, first strict winner kept
		found = 1'b0;
		all_col = 1'b1;
		pick = '0;
		best = 0;
		for (i = 0; i < n; i++) begin
			if (node_color[i] == COLOR_NONE) begin
				all_col = 1'b0;
				row = nbr_rows[i] & pmask;
				if (mode_cfg == MODE_FEWEST_COLORS) begin
					used = '0;
					for (j = 0; j < n; j++)
						if (row[j])
							used[node_color[j]] = 1'b1;
					score = $countones(~used & 4'b1110);
					if (!found || score < best) begin
						best = score;
						pick = 4'(i);
						found = 1'b1;
					end
				end else if (mode_cfg == MODE_MOST_NEIGHBORS) begin
					score = $countones(row);
					if (!found || score > best) begin
						best = score;
						pick = 4'(i);
						found = 1'b1;
					end
				end
			end
		end

		res.color_ok = ok;
		res.next_node = found ? pick : 4'd0;
		res.next_found = found;
		res.all_done = all_col;
		if (found)
			found_count++;
		if (all_col)
			all_colored_count++;
		return res;
	endfunction

	// driver: bursts of transactions separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_selection(item));
				if (burst_left > 0 && pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					burst_left <= burst_left - 1;
				end else begin
					start <= 1'b0;
					gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
				end
			end else if (!start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_items.size() > 0) begin
					start <= 1'b1;
					item <= pending_items.pop_front();
					burst_left <= ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
				end
			end
		end
	end

	// monitor: every strobed result against the oldest expectation
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && done) begin
			results_seen = results_seen + 1;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with no transaction pending:", $realtime,
						" ok=%0b node=%0d found=%0b all=%0b",
						result.color_ok, result.next_node, result.next_found,
						result.all_done);
			end else begin
				exp_res = expected_results.pop_front();
				if (result.color_ok !== exp_res.color_ok
						|| result.next_node !== exp_res.next_node
						|| result.next_found !== exp_res.next_found
						|| result.all_done !== exp_res.all_done) begin
					failures++;
					if (failures <= 10)
						$display("%0t: mismatch expected", $realtime,
							" ok=%0b node=%0d found=%0b all=%0b,",
							exp_res.color_ok, exp_res.next_node, exp_res.next_found,
							exp_res.all_done,
							" got ok=%0b node=%0d found=%0b all=%0b",
							result.color_ok, result.next_node,
							result.next_found, result.all_done);
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NODE_COUNT)
			node_count_cfg = value;
		else
			mode_cfg = value[1:0];
		settings_seen++;
	endtask

	task automatic queue_item(input logic [1:0] kind, input int node, input int other,
			input logic [1:0] color);
		item_t it;
		it.kind = kind;
		it.node = 4'(node);
		it.other_node = 4'(other);
		it.color_code = color;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// block until every queued transaction has produced its result
	task automatic wait_drained();
		while (results_seen < items_queued)
			@(posedge clk);
	endtask

	// one random phase: mostly graph building then coloring, with some noise
	task automatic run_random_phase(input int count, input logic [1:0] mode);
		int lim;
		int r;
		int add_pct;
		int k;
		item_t it;
		write_reg(REG_NODE_COUNT, CFG_W'(count));
		write_reg(REG_HEURISTIC, {3'($urandom_range(0, 7)), mode});
		lim = (count == 0) ? MAX_NODES : ((count > MAX_NODES) ? MAX_NODES : count);
		for (k = 0; k < PHASE_ITEMS; k++) begin
			r = $urandom_range(0, 99);
			add_pct = (k < PHASE_ITEMS / 3) ? 45 : 12;
			if (r < 8) begin
				it = item_t'(12'($urandom));
				pending_items.push_back(it);
				items_queued++;
			end else if (r < 8 + add_pct) begin
				queue_item(KIND_ADD_NEIGHBOR, $urandom_range(0, lim - 1),
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
						: $urandom_range(0, lim - 1),
					2'($urandom_range(0, 3)));
			end else if (r < 70) begin
				queue_item(KIND_ASSIGN_COLOR, $urandom_range(0, lim - 1),
					$urandom_range(0, 15),
					($urandom_range(0, 6) == 0) ? COLOR_NONE : 2'($urandom_range(1, 3)));
			end else begin
				queue_item(($urandom_range(0, 5) == 0) ? KIND_SPARE : KIND_PROBE,
					$urandom_range(0, lim - 1), $urandom_range(0, 15), 2'($urandom_range(0, 3)));
			end
		end
		wait_drained();
	endtask

	// stimulus and end of run
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// no nodes present under the reset settings
		queue_item(KIND_PROBE, 0, 0, COLOR_NONE);
		queue_item(KIND_ADD_NEIGHBOR, 0, 1, COLOR_NONE);
		wait_drained();

		// small graph under the reset heuristic
		write_reg(REG_NODE_COUNT, 5'd4);
		queue_item(KIND_PROBE, 0, 0, COLOR_NONE);
		queue_item(KIND_ADD_NEIGHBOR, 1, 0, COLOR_RED);
		queue_item(KIND_ADD_NEIGHBOR, 1, 2, COLOR_GREEN);
		queue_item(KIND_ADD_NEIGHBOR, 2, 3, COLOR_YELLOW);
		queue_item(KIND_ADD_NEIGHBOR, 3, 15, COLOR_NONE);
		queue_item(KIND_ADD_NEIGHBOR, 15, 0, COLOR_NONE);
		queue_item(KIND_ADD_NEIGHBOR, 0, 3, COLOR_RED);
		queue_item(KIND_ASSIGN_COLOR, 0, 0, COLOR_RED);
		queue_item(KIND_PROBE, 1, 0, COLOR_RED);
		queue_item(KIND_PROBE, 1, 0, COLOR_GREEN);
		queue_item(KIND_ASSIGN_COLOR, 2, 15, COLOR_YELLOW);
		queue_item(KIND_ASSIGN_COLOR, 1, 0, COLOR_GREEN);
		queue_item(KIND_SPARE, 1, 15, COLOR_RED);
		queue_item(KIND_PROBE, 15, 15, COLOR_RED);
		queue_item(KIND_ASSIGN_COLOR, 3, 0, COLOR_RED);
		queue_item(KIND_ASSIGN_COLOR, 0, 0, COLOR_NONE);
		queue_item(KIND_ASSIGN_COLOR, 15, 15, COLOR_YELLOW);
		wait_drained();

		// every node present, most neighbors first
		write_reg(REG_NODE_COUNT, 5'd16);
		write_reg(REG_HEURISTIC, {3'b111, MODE_MOST_NEIGHBORS});
		queue_item(KIND_PROBE, 15, 15, COLOR_YELLOW);
		queue_item(KIND_ADD_NEIGHBOR, 5, 6, COLOR_NONE);
		queue_item(KIND_ADD_NEIGHBOR, 5, 7, COLOR_NONE);
		queue_item(KIND_ADD_NEIGHBOR, 8, 15, COLOR_YELLOW);
		queue_item(KIND_PROBE, 8, 0, COLOR_YELLOW);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++)
			run_random_phase(phase_counts[p], phase_modes[p]);

		repeat (LATENCY_CYCLES + 5) @(posedge clk);
		$display("ran %0d transactions (%0d add, %0d assign, %0d probe, %0d spare kind)",
			items_queued, kind_count[KIND_ADD_NEIGHBOR], kind_count[KIND_ASSIGN_COLOR],
			kind_count[KIND_PROBE], kind_count[KIND_SPARE],
			" over %0d register writes", settings_seen);
		$display("%0d results selected a node, %0d had every present node colored",
			found_count, all_colored_count);
		if (failures == 0 && expected_results.size() == 0) begin
			$display("graph_coloring_node_selector_tb: PASS");
		end else begin
			$display("%0d failures, %0d results never arrived", failures, expected_results.size());
			$display("graph_coloring_node_selector_tb: FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("timeout after %0d of %0d results", results_seen, items_queued);
		$display("graph_coloring_node_selector_tb: FAIL");
		$finish;
	end

endmodule
